FILE: rtl/core/gps_pseudorange_model_core_assert.svh
`ifndef GPS_PSEUDORANGE_MODEL_CORE_ASSERT_SVH
`define GPS_PSEUDORANGE_MODEL_CORE_ASSERT_SVH

// cond true in this cycle requires conseq in the same cycle
`define GPM_ASSERT_NOW(lbl, clk, rst_n, cond, conseq) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("gpm assertion failed");

// cond true in this cycle requires conseq in the next cycle
`define GPM_ASSERT_NEXT(lbl, clk, rst_n, cond, conseq) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("gpm assertion failed");

`endif

FILE: rtl/core/gpm_pkg.sv
package gpm_pkg;
    localparam int LEN_W     = 48;
    localparam int DIFF_W    = LEN_W + 1;
    localparam int DIR_W     = 32;
    localparam int INT_W     = 25;
    localparam int HALF_W    = LEN_W / 2;
    localparam int SQ1_W     = 2 * LEN_W;
    localparam int SQ_W      = 2 * LEN_W + 2;
    localparam int ROOT_BITS = 52;
    localparam int DIV_STEPS = 30;
    localparam int WIDE_W    = 56;

    localparam logic [DIR_W-1:0]        DIR_ONE = 32'h4000_0000;
    localparam logic signed [LEN_W-1:0] LEN_MAX = {1'b0, {(LEN_W-1){1'b1}}};
    localparam logic signed [LEN_W-1:0] LEN_MIN = {1'b1, {(LEN_W-1){1'b0}}};

    typedef logic signed [LEN_W-1:0]  t_len;
    typedef logic signed [DIFF_W-1:0] t_diff;

    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe;

    function automatic t_len sat_len(input logic signed [WIDE_W-1:0] v);
        t_len r;
        if (v > WIDE_W'(LEN_MAX)) begin
            r = LEN_MAX;
        end else if (v < WIDE_W'(LEN_MIN)) begin
            r = LEN_MIN;
        end else begin
            r = v[LEN_W-1:0];
        end
        return r;
    endfunction
endpackage

FILE: rtl/core/gps_pseudorange_model_core.sv
// Pseudorange predictor: takes one receiver state and one satellite position per
// request and returns the predicted position and clock bias, the pseudorange
// (distance plus predicted bias) and the three direction terms in Q1.30. Fully
// pipelined (one request per cycle unless stalled): prediction, squaring, root
// (one result bit per stage over 52 bits), bias add, divider (one quotient bit
// per stage over 30 bits). The whole pipeline holds while a result waits under
// i_stall. The user must write the interval register with i_cfg_wr_en only
// while the block is idle; the block does not enforce this. It resets to 1.0.
module gps_pseudorange_model_core #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [gpm_pkg::INT_W-1:0]           i_cfg_wr_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [gpm_pkg::LEN_W-1:0]    i_pos_x,
    input  logic signed [gpm_pkg::LEN_W-1:0]    i_vel_x,
    input  logic signed [gpm_pkg::LEN_W-1:0]    i_pos_y,
    input  logic signed [gpm_pkg::LEN_W-1:0]    i_vel_y,
    input  logic signed [gpm_pkg::LEN_W-1:0]    i_pos_z,
    input  logic signed [gpm_pkg::LEN_W-1:0]    i_vel_z,
    input  logic signed [gpm_pkg::LEN_W-1:0]    i_clock_bias,
    input  logic signed [gpm_pkg::LEN_W-1:0]    i_clock_drift,
    input  logic signed [gpm_pkg::LEN_W-1:0]    i_sat_x,
    input  logic signed [gpm_pkg::LEN_W-1:0]    i_sat_y,
    input  logic signed [gpm_pkg::LEN_W-1:0]    i_sat_z,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [gpm_pkg::LEN_W-1:0]    o_pred_x,
    output logic signed [gpm_pkg::LEN_W-1:0]    o_pred_y,
    output logic signed [gpm_pkg::LEN_W-1:0]    o_pred_z,
    output logic signed [gpm_pkg::LEN_W-1:0]    o_pred_bias,
    output logic signed [gpm_pkg::LEN_W-1:0]    o_pred_range,
    output logic signed [gpm_pkg::DIR_W-1:0]    o_dir_x,
    output logic signed [gpm_pkg::DIR_W-1:0]    o_dir_y,
    output logic signed [gpm_pkg::DIR_W-1:0]    o_dir_z
);
    localparam int LW      = gpm_pkg::LEN_W;
    localparam int DW      = gpm_pkg::DIFF_W;
    localparam int NB      = gpm_pkg::ROOT_BITS;
    localparam int P_SIDE  = 3 * LW;
    localparam int Q_SIDE  = 4 * LW;
    localparam int R_SIDE  = 3 * DW + Q_SIDE;
    localparam int D_SIDE  = LW + Q_SIDE;

    logic [gpm_pkg::INT_W-1:0]   r_interval;
    logic                        w_en;
    gpm_pkg::t_pipe              w_p_ctl, w_q_ctl, w_r_ctl, w_d_ctl;

    gpm_pkg::t_len               w_pos  [4];
    gpm_pkg::t_len               w_rate [4];
    gpm_pkg::t_len               w_pred [4];
    logic [P_SIDE-1:0]           w_p_side_in, w_p_side;
    logic                        w_p_vld;

    gpm_pkg::t_len               w_q_pred [3];
    gpm_pkg::t_len               w_q_sat  [3];
    logic [Q_SIDE-1:0]           w_q_side_in, w_q_side;
    logic                        w_q_vld;
    logic [gpm_pkg::SQ_W-1:0]    w_sum;
    gpm_pkg::t_diff              w_q_diff [3];

    logic [R_SIDE-1:0]           w_r_side_in, w_r_side;
    logic                        w_r_vld;
    logic [NB-1:0]               w_root;

    logic                        r_rng_vld;
    gpm_pkg::t_len               r_rng;
    gpm_pkg::t_diff              r_rng_diff [3];
    logic [Q_SIDE-1:0]           r_rng_side;

    logic [D_SIDE-1:0]           w_d_side;
    logic [gpm_pkg::DIR_W-1:0]   w_dir [3];

    assign w_en        = !(o_valid && i_stall);
    assign o_stall     = o_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= gpm_pkg::INT_W'(1) << FRACTION_BITS;
        end else if (i_cfg_wr_en) begin
            r_interval <= i_cfg_wr_data;
        end
    end

    assign w_pos[0]  = i_pos_x;
    assign w_pos[1]  = i_pos_y;
    assign w_pos[2]  = i_pos_z;
    assign w_pos[3]  = i_clock_bias;
    assign w_rate[0] = i_vel_x;
    assign w_rate[1] = i_vel_y;
    assign w_rate[2] = i_vel_z;
    assign w_rate[3] = i_clock_drift;
    assign w_p_side_in = {i_sat_z, i_sat_y, i_sat_x};
    assign w_p_ctl   = '{en: w_en, valid: i_valid};

    gpm_predict #(
        .FRAC_BITS (FRACTION_BITS),
        .SIDE_W    (P_SIDE)
    ) u_predict (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_p_ctl),
        .i_interval (r_interval),
        .i_pos      (w_pos),
        .i_rate     (w_rate),
        .i_side     (w_p_side_in),
        .o_valid    (w_p_vld),
        .o_pred     (w_pred),
        .o_side     (w_p_side)
    );

    assign w_q_pred[0] = w_pred[0];
    assign w_q_pred[1] = w_pred[1];
    assign w_q_pred[2] = w_pred[2];
    assign w_q_sat[0]  = w_p_side[LW-1:0];
    assign w_q_sat[1]  = w_p_side[2*LW-1:LW];
    assign w_q_sat[2]  = w_p_side[3*LW-1:2*LW];
    assign w_q_side_in = {w_pred[3], w_pred[2], w_pred[1], w_pred[0]};
    assign w_q_ctl     = '{en: w_en, valid: w_p_vld};

    gpm_square #(
        .SIDE_W (Q_SIDE)
    ) u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_q_ctl),
        .i_pred  (w_q_pred),
        .i_sat   (w_q_sat),
        .i_side  (w_q_side_in),
        .o_valid (w_q_vld),
        .o_sum   (w_sum),
        .o_diff  (w_q_diff),
        .o_side  (w_q_side)
    );

    assign w_r_side_in = {w_q_diff[2], w_q_diff[1], w_q_diff[0], w_q_side};
    assign w_r_ctl     = '{en: w_en, valid: w_q_vld};

    gpm_sqrt #(
        .SIDE_W (R_SIDE)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_r_ctl),
        .i_rad   (w_sum),
        .i_side  (w_r_side_in),
        .o_valid (w_r_vld),
        .o_root  (w_root),
        .o_side  (w_r_side)
    );

    // pseudorange = root + predicted bias
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rng_vld <= 1'b0;
        end else if (w_en) begin
            r_rng_vld <= w_r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rng <= gpm_pkg::sat_len(
                gpm_pkg::WIDE_W'($signed({1'b0, w_root}))
                + gpm_pkg::WIDE_W'($signed(w_r_side[4*LW-1:3*LW])));
            for (int k = 0; k < 3; k++) begin
                r_rng_diff[k] <= w_r_side[Q_SIDE + k*DW +: DW];
            end
            r_rng_side <= w_r_side[Q_SIDE-1:0];
        end
    end

    assign w_d_ctl = '{en: w_en, valid: r_rng_vld};

    gpm_divide #(
        .SIDE_W (D_SIDE)
    ) u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_d_ctl),
        .i_diff  (r_rng_diff),
        .i_range (r_rng),
        .i_side  ({r_rng, r_rng_side}),
        .o_valid (o_valid),
        .o_dir   (w_dir),
        .o_side  (w_d_side)
    );

    assign o_pred_x     = w_d_side[LW-1:0];
    assign o_pred_y     = w_d_side[2*LW-1:LW];
    assign o_pred_z     = w_d_side[3*LW-1:2*LW];
    assign o_pred_bias  = w_d_side[4*LW-1:3*LW];
    assign o_pred_range = w_d_side[5*LW-1:4*LW];
    assign o_dir_x      = w_dir[0];
    assign o_dir_y      = w_dir[1];
    assign o_dir_z      = w_dir[2];
endmodule

FILE: rtl/core/gpm_predict.sv
module gpm_predict #(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 144
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gpm_pkg::t_pipe                i_ctl,
    input  logic [gpm_pkg::INT_W-1:0]     i_interval,
    input  gpm_pkg::t_len                 i_pos  [4],
    input  gpm_pkg::t_len                 i_rate [4],
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_valid,
    output gpm_pkg::t_len                 o_pred [4],
    output logic [SIDE_W-1:0]             o_side
);
    localparam int LW   = gpm_pkg::LEN_W;
    localparam int HW   = gpm_pkg::HALF_W;
    localparam int PP_W = HW + gpm_pkg::INT_W;
    localparam int PR_W = PP_W + HW;

    logic                r1_vld, r2_vld, r3_vld;
    logic [LW-1:0]       r1_mag [4];
    logic                r1_neg [4];
    gpm_pkg::t_len       r1_pos [4];
    logic [SIDE_W-1:0]   r1_side;
    logic [PP_W-1:0]     r2_pl  [4];
    logic [PP_W-1:0]     r2_ph  [4];
    logic                r2_neg [4];
    gpm_pkg::t_len       r2_pos [4];
    logic [SIDE_W-1:0]   r2_side;
    gpm_pkg::t_diff      r3_scl [4];
    gpm_pkg::t_len       r3_pos [4];
    logic [SIDE_W-1:0]   r3_side;
    gpm_pkg::t_diff      n3_scl [4];

    always_comb begin
        logic [PR_W-1:0] prod;
        logic [PR_W-1:0] qf;
        logic [LW-1:0]   q;
        for (int k = 0; k < 4; k++) begin
            prod = {r2_ph[k], {HW{1'b0}}} + PR_W'(r2_pl[k]);
            qf   = prod >> FRAC_BITS;
            q    = (qf > (PR_W'(1) << (LW - 1))) ? (LW'(1) << (LW - 1)) : qf[LW-1:0];
            if (r2_neg[k]) begin
                n3_scl[k] = -gpm_pkg::DIFF_W'(q);
            end else if (q[LW-1]) begin
                n3_scl[k] = gpm_pkg::DIFF_W'(gpm_pkg::LEN_MAX);
            end else begin
                n3_scl[k] = gpm_pkg::DIFF_W'(q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r1_vld  <= i_ctl.valid;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            o_valid <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int k = 0; k < 4; k++) begin
                r1_mag[k] <= i_rate[k][LW-1] ? LW'(-i_rate[k]) : LW'(i_rate[k]);
                r1_neg[k] <= i_rate[k][LW-1];
                r1_pos[k] <= i_pos[k];
                r2_pl[k]  <= PP_W'(r1_mag[k][HW-1:0]) * PP_W'(i_interval);
                r2_ph[k]  <= PP_W'(r1_mag[k][LW-1:HW]) * PP_W'(i_interval);
                r2_neg[k] <= r1_neg[k];
                r2_pos[k] <= r1_pos[k];
                r3_scl[k] <= n3_scl[k];
                r3_pos[k] <= r2_pos[k];
                o_pred[k] <= gpm_pkg::sat_len(gpm_pkg::WIDE_W'(r3_pos[k])
                                              + gpm_pkg::WIDE_W'(r3_scl[k]));
            end
            r1_side <= i_side;
            r2_side <= r1_side;
            r3_side <= r2_side;
            o_side  <= r3_side;
        end
    end
endmodule

FILE: rtl/core/gpm_square.sv
module gpm_square #(
    parameter int SIDE_W = 192
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  gpm_pkg::t_pipe             i_ctl,
    input  gpm_pkg::t_len              i_pred [3],
    input  gpm_pkg::t_len              i_sat  [3],
    input  logic [SIDE_W-1:0]          i_side,
    output logic                       o_valid,
    output logic [gpm_pkg::SQ_W-1:0]   o_sum,
    output gpm_pkg::t_diff             o_diff [3],
    output logic [SIDE_W-1:0]          o_side
);
    localparam int LW  = gpm_pkg::LEN_W;
    localparam int HW  = gpm_pkg::HALF_W;
    localparam int DW  = gpm_pkg::DIFF_W;
    localparam int S1W = gpm_pkg::SQ1_W;
    localparam int SW  = gpm_pkg::SQ_W;

    logic              r1_vld, r2_vld, r3_vld;
    gpm_pkg::t_diff    r1_diff [3];
    gpm_pkg::t_diff    r2_diff [3];
    gpm_pkg::t_diff    r3_diff [3];
    logic [2*HW-1:0]   r2_hh [3];
    logic [2*HW-1:0]   r2_hl [3];
    logic [2*HW-1:0]   r2_ll [3];
    logic [S1W-1:0]    r3_sq [3];
    logic [SIDE_W-1:0] r1_side, r2_side, r3_side;
    logic [LW-1:0]     w_mag [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_mag[k] = r1_diff[k][DW-1] ? LW'(-r1_diff[k]) : LW'(r1_diff[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r1_vld  <= i_ctl.valid;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            o_valid <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int k = 0; k < 3; k++) begin
                r1_diff[k] <= DW'(i_pred[k]) - DW'(i_sat[k]);
                r2_diff[k] <= r1_diff[k];
                r2_hh[k]   <= (2*HW)'(w_mag[k][LW-1:HW]) * (2*HW)'(w_mag[k][LW-1:HW]);
                r2_hl[k]   <= (2*HW)'(w_mag[k][LW-1:HW]) * (2*HW)'(w_mag[k][HW-1:0]);
                r2_ll[k]   <= (2*HW)'(w_mag[k][HW-1:0]) * (2*HW)'(w_mag[k][HW-1:0]);
                r3_diff[k] <= r2_diff[k];
                r3_sq[k]   <= (S1W'(r2_hh[k]) << (2*HW)) + (S1W'(r2_hl[k]) << (HW + 1))
                              + S1W'(r2_ll[k]);
                o_diff[k]  <= r3_diff[k];
            end
            o_sum   <= SW'(r3_sq[0]) + SW'(r3_sq[1]) + SW'(r3_sq[2]);
            r1_side <= i_side;
            r2_side <= r1_side;
            r3_side <= r2_side;
            o_side  <= r3_side;
        end
    end
endmodule

FILE: rtl/core/gpm_sqrt.sv
module gpm_sqrt #(
    parameter int SIDE_W = 339
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gpm_pkg::t_pipe                  i_ctl,
    input  logic [gpm_pkg::SQ_W-1:0]        i_rad,
    input  logic [SIDE_W-1:0]               i_side,
    output logic                            o_valid,
    output logic [gpm_pkg::ROOT_BITS-1:0]   o_root,
    output logic [SIDE_W-1:0]               o_side
);
    localparam int NB = gpm_pkg::ROOT_BITS;
    localparam int SW = gpm_pkg::SQ_W;
    localparam int TW = 2 * NB + 2;

    logic              r_vld  [NB+1];
    logic [SW-1:0]     r_rem  [NB+1];
    logic [NB-1:0]     r_root [NB+1];
    logic [SIDE_W-1:0] r_side [NB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld[0] <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_rem[0]  <= i_rad;
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar g = 0; g < NB; g++) begin : g_bit
        localparam int B = NB - 1 - g;
        logic [TW-1:0] trial;

        // (r + 2^B)^2 - r^2
        assign trial = (TW'(r_root[g]) << (B + 1)) | (TW'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                if (trial <= TW'(r_rem[g])) begin
                    r_rem[g+1]  <= r_rem[g] - SW'(trial);
                    r_root[g+1] <= r_root[g] | (NB'(1) << B);
                end else begin
                    r_rem[g+1]  <= r_rem[g];
                    r_root[g+1] <= r_root[g];
                end
                r_side[g+1] <= r_side[g];
            end
        end
    end

    assign o_valid = r_vld[NB];
    assign o_root  = r_root[NB];
    assign o_side  = r_side[NB];
endmodule

FILE: rtl/core/gpm_divide.sv
module gpm_divide #(
    parameter int SIDE_W = 240
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gpm_pkg::t_pipe              i_ctl,
    input  gpm_pkg::t_diff              i_diff [3],
    input  gpm_pkg::t_len               i_range,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic [gpm_pkg::DIR_W-1:0]   o_dir [3],
    output logic [SIDE_W-1:0]           o_side
);
    localparam int LW = gpm_pkg::LEN_W;
    localparam int DW = gpm_pkg::DIFF_W;
    localparam int NS = gpm_pkg::DIV_STEPS;
    localparam int OW = gpm_pkg::DIR_W;

    logic              r_vld  [NS+1];
    logic [LW-1:0]     r_rem  [NS+1][3];
    logic [NS-1:0]     r_quo  [NS+1][3];
    logic [LW-1:0]     r_mr   [NS+1];
    logic [2:0]        r_neg  [NS+1];
    logic [2:0]        r_zero [NS+1];
    logic [2:0]        r_cap  [NS+1];
    logic [SIDE_W-1:0] r_side [NS+1];
    logic [LW-1:0]     w_md   [3];
    logic [LW-1:0]     w_mr;
    logic [OW-1:0]     w_out  [3];

    always_comb begin
        w_mr = i_range[LW-1] ? LW'(-i_range) : LW'(i_range);
        for (int k = 0; k < 3; k++) begin
            w_md[k] = i_diff[k][DW-1] ? LW'(-i_diff[k]) : LW'(i_diff[k]);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_zero[NS][k]) begin
                w_out[k] = '0;
            end else if (r_cap[NS][k]) begin
                w_out[k] = gpm_pkg::DIR_ONE;
            end else begin
                w_out[k] = OW'(r_quo[NS][k]);
            end
            if (r_neg[NS][k]) begin
                w_out[k] = -w_out[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
            o_valid  <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld[0] <= i_ctl.valid;
            o_valid  <= r_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int k = 0; k < 3; k++) begin
                r_rem[0][k]  <= w_md[k];
                r_quo[0][k]  <= '0;
                r_zero[0][k] <= (w_md[k] == '0);
                r_cap[0][k]  <= (w_md[k] >= w_mr);
                r_neg[0][k]  <= (w_mr == '0) ? i_diff[k][DW-1]
                                             : (i_diff[k][DW-1] != i_range[LW-1]);
                o_dir[k]     <= w_out[k];
            end
            r_mr[0]   <= w_mr;
            r_side[0] <= i_side;
            o_side    <= r_side[NS];
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            logic [LW:0] rem2;
            if (i_ctl.en) begin
                for (int k = 0; k < 3; k++) begin
                    rem2 = {r_rem[g][k], 1'b0};
                    if (rem2 >= (LW+1)'(r_mr[g])) begin
                        r_rem[g+1][k] <= LW'(rem2 - (LW+1)'(r_mr[g]));
                        r_quo[g+1][k] <= {r_quo[g][k][NS-2:0], 1'b1};
                    end else begin
                        r_rem[g+1][k] <= LW'(rem2);
                        r_quo[g+1][k] <= {r_quo[g][k][NS-2:0], 1'b0};
                    end
                end
                r_mr[g+1]   <= r_mr[g];
                r_neg[g+1]  <= r_neg[g];
                r_zero[g+1] <= r_zero[g];
                r_cap[g+1]  <= r_cap[g];
                r_side[g+1] <= r_side[g];
            end
        end
    end
endmodule

FILE: rtl/core/gpm_checker.sv
`include "gps_pseudorange_model_core_assert.svh"

module gpm_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic signed [gpm_pkg::LEN_W-1:0]  o_pred_range,
    input logic signed [gpm_pkg::DIR_W-1:0]  o_dir_x,
    input logic signed [gpm_pkg::DIR_W-1:0]  o_dir_y,
    input logic signed [gpm_pkg::DIR_W-1:0]  o_dir_z
);
    localparam logic signed [gpm_pkg::DIR_W-1:0] DMAX = 32'sd1073741824;

    logic w_hold;
    logic w_dir_ok;

    assign w_hold   = o_valid && i_stall;
    assign w_dir_ok = (o_dir_x <= DMAX) && (o_dir_x >= -DMAX)
                   && (o_dir_y <= DMAX) && (o_dir_y >= -DMAX)
                   && (o_dir_z <= DMAX) && (o_dir_z >= -DMAX);

    `GPM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_hold, o_valid)
    `GPM_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, w_hold, $stable(o_pred_range) && $stable(o_dir_x))
    `GPM_ASSERT_NOW(a_in_stall, i_clk, i_rst_n, 1'b1, o_stall == w_hold)
    `GPM_ASSERT_NOW(a_dir_range, i_clk, i_rst_n, o_valid, w_dir_ok)
endmodule

bind gps_pseudorange_model_core gpm_checker u_gpm_checker (.*);
